// File: rtl/rslr_pkg.sv
package rslr_pkg;

   // Line mode held by the controller; the divide states wait for the run split.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VERT,
      ST_HORZ,
      ST_XDIV,
      ST_YDIV,
      ST_XRUNS,
      ST_YRUNS
   } state_type;

   // Shape of a line as seen from its endpoints at load time.
   typedef enum logic [2:0] {
      KIND_EMPTY,
      KIND_VERT,
      KIND_HORZ,
      KIND_XRUNS,
      KIND_YRUNS
   } kind_type;

   typedef struct packed {
      logic      load;
      logic      step;
      logic      div_start;
      state_type mode;
   } ctrl_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     div_done;
      logic     step_done;
   } dp_status_type;

endpackage

// File: rtl/rslr_div.sv
module rslr_div #(
   parameter int W = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   localparam int CW = $clog2(W);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    rem_sh;
   logic [W:0]    diff;
   logic          fits;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      fits    = rem_sh >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle, most significant first
         rem_in = fits ? diff[W-1:0] : rem_sh[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/rslr_datapath.sv
module rslr_datapath #(
   parameter int COORD_BITS = 12,
   parameter int COLOR_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rslr_pkg::ctrl_cmd_type   cmd,
   output rslr_pkg::dp_status_type  status,
   input  logic [COORD_BITS-1:0]    req_x_start,
   input  logic [COORD_BITS-1:0]    req_y_start,
   input  logic [COORD_BITS-1:0]    req_x_end,
   input  logic [COORD_BITS-1:0]    req_y_end,
   input  logic [COLOR_BITS-1:0]    req_color,
   output logic                     rsp_pixel_valid,
   output logic [COORD_BITS-1:0]    rsp_pixel_x,
   output logic [COORD_BITS-1:0]    rsp_pixel_y,
   output logic [COLOR_BITS-1:0]    rsp_pixel_color,
   output logic                     rsp_line_done
);
   import rslr_pkg::*;

   localparam int W = COORD_BITS;

   logic [W-1:0]          cur_x_ff, cur_x_in;
   logic [W-1:0]          cur_y_ff, cur_y_in;
   logic [W-1:0]          run_pos_ff, run_pos_in;
   logic [W-1:0]          span_end_ff, span_end_in;
   logic [W-1:0]          run_q_ff, run_q_in;
   logic [W-1:0]          run_r_ff, run_r_in;
   logic [W-1:0]          err_acc_ff, err_acc_in;
   logic [W-1:0]          minor_total_ff, minor_total_in;
   logic [W-1:0]          minor_count_ff, minor_count_in;
   logic [W:0]            run_left_ff, run_left_in;
   logic                  x_dec_ff, x_dec_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   logic                  pv_ff, pv_in;
   logic [W-1:0]          px_ff, px_in;
   logic [W-1:0]          py_ff, py_in;
   logic [COLOR_BITS-1:0] pc_ff, pc_in;
   logic                  done_ff, done_in;

   // load setup
   logic [W-1:0] xs, ys, xe, ye, dx, dy, major, minor;
   logic         swap, x_dec_ld;
   kind_type     kind;

   // run stepping
   logic         new_run;
   logic [W:0]   sum;
   logic         ge;
   logic [W:0]   len;
   logic [W-1:0] acc_next, mc_next, rp, cx, cy;
   logic [W:0]   rl, rl_next;
   logic         div_done;
   logic [W-1:0] div_q, div_r;

   always_comb begin
      swap     = req_y_end < req_y_start;
      xs       = swap ? req_x_end   : req_x_start;
      xe       = swap ? req_x_start : req_x_end;
      ys       = swap ? req_y_end   : req_y_start;
      ye       = swap ? req_y_start : req_y_end;
      x_dec_ld = xe < xs;
      dx       = x_dec_ld ? xs - xe : xe - xs;
      dy       = ye - ys;
      major    = (dx >= dy) ? dx : dy;
      minor    = (dx >= dy) ? dy : dx;
      if (req_x_start == req_x_end) begin
         kind = (req_y_start != req_y_end) ? KIND_VERT : KIND_EMPTY;
      end else if (req_y_start == req_y_end) begin
         kind = KIND_HORZ;
      end else begin
         kind = (dx >= dy) ? KIND_XRUNS : KIND_YRUNS;
      end
   end

   rslr_div #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (major),
      .divisor   (minor),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      new_run  = run_left_ff == '0;
      sum      = {1'b0, err_acc_ff} + {1'b0, run_r_ff};
      ge       = sum >= {1'b0, minor_total_ff};
      len      = {1'b0, run_q_ff} + {{W{1'b0}}, ge};
      acc_next = ge ? W'(sum - {1'b0, minor_total_ff}) : sum[W-1:0];
      mc_next  = new_run ? minor_count_ff + 1'b1 : minor_count_ff;
      rl       = new_run ? len : run_left_ff;
      rl_next  = rl - 1'b1;
      rp       = run_pos_ff;
      cx       = cur_x_ff;
      cy       = cur_y_ff;
      if (new_run) begin
         if (cmd.mode == ST_XRUNS) begin
            if (x_dec_ff) begin
               cx = cur_x_ff - len[W-1:0];
               rp = cx;
            end else begin
               rp = cur_x_ff;
               cx = cur_x_ff + len[W-1:0];
            end
         end else begin
            rp = cur_y_ff;
            cy = cur_y_ff + len[W-1:0];
         end
      end
   end

   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      run_pos_in     = run_pos_ff;
      span_end_in    = span_end_ff;
      run_q_in       = run_q_ff;
      run_r_in       = run_r_ff;
      err_acc_in     = err_acc_ff;
      minor_total_in = minor_total_ff;
      minor_count_in = minor_count_ff;
      run_left_in    = run_left_ff;
      x_dec_in       = x_dec_ff;
      color_in       = color_ff;
      pv_in          = pv_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      pc_in          = pc_ff;
      done_in        = done_ff;

      if (div_done) begin
         run_q_in = div_q;
         run_r_in = div_r;
      end

      if (cmd.load) begin
         color_in       = req_color;
         err_acc_in     = '0;
         minor_count_in = '0;
         run_left_in    = '0;
         minor_total_in = minor;
         x_dec_in       = 1'b0;
         pv_in          = 1'b0;
         px_in          = '0;
         py_in          = '0;
         pc_in          = '0;
         done_in        = kind == KIND_EMPTY;
         unique case (kind)
            KIND_VERT: begin
               cur_x_in    = req_x_start;
               cur_y_in    = ys;
               span_end_in = ye;
            end
            KIND_HORZ: begin
               cur_y_in    = req_y_start;
               cur_x_in    = x_dec_ld ? xe : xs;
               span_end_in = x_dec_ld ? xs : xe;
            end
            KIND_XRUNS, KIND_YRUNS: begin
               cur_x_in = xs;
               cur_y_in = ys;
               x_dec_in = x_dec_ld;
            end
            default: begin
            end
         endcase
      end else if (cmd.step) begin
         pv_in   = 1'b0;
         px_in   = '0;
         py_in   = '0;
         pc_in   = '0;
         done_in = 1'b1;
         unique case (cmd.mode)
            ST_VERT: begin
               pv_in    = 1'b1;
               px_in    = cur_x_ff;
               py_in    = cur_y_ff;
               pc_in    = color_ff;
               cur_y_in = cur_y_ff + 1'b1;
               done_in  = (cur_y_ff + 1'b1) == span_end_ff;
            end
            ST_HORZ: begin
               pv_in    = 1'b1;
               px_in    = cur_x_ff;
               py_in    = cur_y_ff;
               pc_in    = color_ff;
               cur_x_in = cur_x_ff + 1'b1;
               done_in  = (cur_x_ff + 1'b1) == span_end_ff;
            end
            ST_XRUNS, ST_YRUNS: begin
               pv_in          = 1'b1;
               pc_in          = color_ff;
               px_in          = (cmd.mode == ST_XRUNS) ? rp : cx;
               py_in          = (cmd.mode == ST_XRUNS) ? cy : rp;
               if (new_run) begin
                  err_acc_in = acc_next;
               end
               minor_count_in = mc_next;
               run_pos_in     = rp + 1'b1;
               run_left_in    = rl_next;
               cur_x_in       = cx;
               cur_y_in       = cy;
               done_in        = 1'b0;
               if (rl_next == '0) begin
                  // run finished: take the minor-axis step
                  if (cmd.mode == ST_XRUNS) begin
                     cur_y_in = cy + 1'b1;
                  end else begin
                     cur_x_in = x_dec_ff ? cx - 1'b1 : cx + 1'b1;
                  end
                  done_in = mc_next >= minor_total_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      run_pos_ff     <= run_pos_in;
      span_end_ff    <= span_end_in;
      run_q_ff       <= run_q_in;
      run_r_ff       <= run_r_in;
      err_acc_ff     <= err_acc_in;
      minor_total_ff <= minor_total_in;
      minor_count_ff <= minor_count_in;
      run_left_ff    <= run_left_in;
      x_dec_ff       <= x_dec_in;
      color_ff       <= color_in;
      pv_ff          <= pv_in;
      px_ff          <= px_in;
      py_ff          <= py_in;
      pc_ff          <= pc_in;
      done_ff        <= done_in;
   end

   assign status.kind      = kind;
   assign status.div_done  = div_done;
   assign status.step_done = done_in;

   assign rsp_pixel_valid = pv_ff;
   assign rsp_pixel_x     = px_ff;
   assign rsp_pixel_y     = py_ff;
   assign rsp_pixel_color = pc_ff;
   assign rsp_line_done   = done_ff;

`ifndef SYNTHESIS
   a_acc_below_minor: assert property (@(posedge clock) disable iff (reset)
      (cmd.mode == ST_XRUNS || cmd.mode == ST_YRUNS) |-> err_acc_ff < minor_total_ff)
      else $error("remainder accumulator reached minor delta");
   a_run_len_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.mode == ST_XRUNS || cmd.mode == ST_YRUNS)
      |-> run_left_ff <= ({1'b0, run_q_ff} + 1'b1))
      else $error("pixels left in run exceed longest run");
   a_runs_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.mode == ST_XRUNS || cmd.mode == ST_YRUNS) |-> minor_count_ff <= minor_total_ff)
      else $error("more runs started than minor delta");
`endif

endmodule

// File: rtl/rslr_ctrl.sv
module rslr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_cmd,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  rslr_pkg::dp_status_type status,
   output rslr_pkg::ctrl_cmd_type  cmd
);
   import rslr_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      dividing;
   logic      accept;
   logic      is_load;

   always_comb begin
      dividing  = state_ff == ST_XDIV || state_ff == ST_YDIV;
      req_stall = dividing || (rsp_valid_ff && rsp_stall);
      accept    = req_valid && !req_stall;
      is_load   = req_cmd == 1'b0;

      cmd.load      = accept && is_load;
      cmd.step      = accept && !is_load;
      cmd.div_start = cmd.load &&
                      (status.kind == KIND_XRUNS || status.kind == KIND_YRUNS);
      cmd.mode      = state_ff;

      // every accepted item leaves one result in the output register
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      state_in = state_ff;
      if (cmd.load) begin
         unique case (status.kind)
            KIND_VERT:  state_in = ST_VERT;
            KIND_HORZ:  state_in = ST_HORZ;
            KIND_XRUNS: state_in = ST_XDIV;
            KIND_YRUNS: state_in = ST_YDIV;
            default:    state_in = ST_IDLE;
         endcase
      end else begin
         unique case (state_ff)
            ST_XDIV: begin
               if (status.div_done) state_in = ST_XRUNS;
            end
            ST_YDIV: begin
               if (status.div_done) state_in = ST_YRUNS;
            end
            ST_VERT, ST_HORZ, ST_XRUNS, ST_YRUNS: begin
               if (cmd.step && status.step_done) state_in = ST_IDLE;
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_hold_while_dividing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_XDIV || state_ff == ST_YDIV) |-> req_stall)
      else $error("input taken while run split in progress");
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted item left no result");
   a_done_only_dividing: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_XDIV || state_ff == ST_YDIV))
      else $error("divider finished outside divide state");
`endif

endmodule

// File: rtl/run_slice_line_rasterizer_top.sv
// Run-slice line rasterizer.
// Input channel (req_*): a transfer with req_cmd = 0 loads a line from its
// two endpoints and color; a transfer with req_cmd = 1 asks for the next
// pixel. Every input transfer yields exactly one result transfer on rsp_*,
// carrying at most one pixel and a line_done flag.
// Latency: a result is presented in the cycle after its input transfer and
// sits in an output register until the receiver takes it.
// Step items and straight or empty loads can be taken back to back while
// the receiver does not stall. A diagonal load sends its own result at once,
// then the input is held off while the radix-2 divider splits the major
// delta by the minor delta into run quotient and remainder, one quotient
// bit per cycle.
// Reset leaves the block idle with no result pending; steps while idle
// report no pixel and line_done set.
// When the receiver stalls with a result pending, req_stall rises and no
// further input is taken until the result transfer completes.
module run_slice_line_rasterizer_top #(
   parameter int COORD_BITS = 12,
   parameter int COLOR_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   input  logic [COLOR_BITS-1:0] req_color,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_pixel_valid,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_BITS-1:0] rsp_pixel_color,
   output logic                  rsp_line_done
);
   import rslr_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // controller: line mode, input hold-off and result handshake
   rslr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: line setup, run stepping, divider and result payload
   rslr_datapath #(
      .COORD_BITS (COORD_BITS),
      .COLOR_BITS (COLOR_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_color       (req_color),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_line_done   (rsp_line_done)
   );

endmodule
